/* hdl/kmmc_pkg.sv */
// Shared types and constants for the k-means clustering block.
// Used by every module of the block; has no dependencies of its own.
package kmmc_pkg;

  localparam int unsigned DIMS       = 3;
  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned DIST_W     = 10;
  localparam int unsigned DIM_IW     = 2;
  localparam int unsigned IDX_W      = 12;

  localparam logic [12:0] NUM_POINTS_RST     = 13'd4096;
  localparam logic [4:0]  NUM_CLUSTERS_RST   = 5'd16;
  localparam logic [7:0]  MAX_ITERATIONS_RST = 8'd255;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [DIMS-1:0] point_t;

  typedef enum logic [1:0] {
    FUNC_LOAD_POINT = 2'd0,
    FUNC_LOAD_SEED  = 2'd1,
    FUNC_RUN        = 2'd2,
    FUNC_READ       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_NUM_POINTS     = 2'd0,
    CFG_NUM_CLUSTERS   = 2'd1,
    CFG_MAX_ITERATIONS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]       pad;
    coord_t           coord_c;
    coord_t           coord_b;
    coord_t           coord_a;
    logic [IDX_W-1:0] index;
  } item_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       converged;
    logic [7:0] rounds;
    coord_t     mean_c;
    coord_t     mean_b;
    coord_t     mean_a;
    logic [3:0] cluster;
  } result_t;

endpackage

/* hdl/kmmc_lane.sv */
// One distance lane: registered Manhattan distance from a point to one centroid.
// Depends on kmmc_pkg. A disabled lane reports the largest code so it never wins.
module kmmc_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  kmmc_pkg::point_t              point_i,
  input  kmmc_pkg::point_t              cent_i,
  output logic [kmmc_pkg::DIST_W:0]     dist_o
);

  logic [kmmc_pkg::DIST_W-1:0] sum;
  logic [kmmc_pkg::DIST_W:0]   dist_q;

  always_comb begin
    sum = '0;
    for (int d = 0; d < int'(kmmc_pkg::DIMS); d++) begin
      if (point_i[d] >= cent_i[d]) begin
        sum = sum + kmmc_pkg::DIST_W'(point_i[d] - cent_i[d]);
      end else begin
        sum = sum + kmmc_pkg::DIST_W'(cent_i[d] - point_i[d]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= en_i ? {1'b0, sum} : '1;
  end

  assign dist_o = dist_q;

endmodule

/* hdl/kmmc_merge.sv */
// Registered minimum tree over the lane distances, with every tree level registered.
// Depends on kmmc_pkg. On equal distances the lower lane index wins.
module kmmc_merge #(
  parameter int unsigned NUM = 16
) (
  input  logic                          clk_i,
  input  logic [kmmc_pkg::DIST_W:0]     dist_i [NUM],
  output logic [$clog2(NUM)-1:0]        idx_o
);

  localparam int unsigned LV = $clog2(NUM);
  localparam int unsigned P  = 1 << LV;

  logic [kmmc_pkg::DIST_W:0] node_d_q [P];
  logic [LV-1:0]             node_i_q [P];
  logic [kmmc_pkg::DIST_W:0] tree_d   [2*P];
  logic [LV-1:0]             tree_i   [2*P];

  always_comb begin
    tree_d[0] = '1;
    tree_i[0] = '0;
    for (int unsigned i = 1; i < 2 * P; i++) begin
      if (i >= P) begin
        tree_d[i] = (i - P < NUM) ? dist_i[i-P] : '1;
        tree_i[i] = LV'(i - P);
      end else begin
        tree_d[i] = node_d_q[i];
        tree_i[i] = node_i_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_d_q[0] <= '1;
    node_i_q[0] <= '0;
    for (int unsigned i = 1; i < P; i++) begin
      if (tree_d[2*i+1] < tree_d[2*i]) begin
        node_d_q[i] <= tree_d[2*i+1];
        node_i_q[i] <= tree_i[2*i+1];
      end else begin
        node_d_q[i] <= tree_d[2*i];
        node_i_q[i] <= tree_i[2*i];
      end
    end
  end

  assign idx_o = node_i_q[1];

endmodule

/* hdl/kmmc_div.sv */
// Bit-serial divider for centroid means, one quotient bit per cycle.
// Depends on kmmc_pkg. The quotient is known to fit in one coordinate.
module kmmc_div #(
  parameter int unsigned CNT_W = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [kmmc_pkg::COORD_BITS+CNT_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]                       divisor_i,
  output logic                                   done_o,
  output kmmc_pkg::coord_t                       quot_o
);

  localparam int unsigned SUM_W = kmmc_pkg::COORD_BITS + CNT_W;
  localparam int unsigned STEP_W = $clog2(kmmc_pkg::COORD_BITS);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(kmmc_pkg::COORD_BITS - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  rem_q;
  logic [SUM_W-1:0]  dsh_q;
  kmmc_pkg::coord_t  quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= SUM_W'(divisor_i) << (kmmc_pkg::COORD_BITS - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_q  <= rem_q - dsh_q;
        quot_q <= {quot_q[kmmc_pkg::COORD_BITS-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[kmmc_pkg::COORD_BITS-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hdl/kmeans_manhattan_clustering.sv */
// Top level of the Manhattan-distance k-means engine: point and assignment memories,
// centroid registers, run sequencer. Depends on kmmc_pkg, kmmc_lane, kmmc_merge, kmmc_div.
//
// A run item holds the input side for its whole duration: each round streams the
// points through one read port of the point memory at one point per cycle, with one
// lane per cluster computing distances in parallel and a registered minimum tree
// merging them. After a pass that changed any assignment, the shared serial divider
// computes each non-empty cluster's three means, one coordinate at a time. No
// clearing pass is needed after reset.
module kmeans_manhattan_clustering #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // index, coord_a, coord_b, coord_c
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // cluster, mean_a, mean_b, mean_c, rounds, converged
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned PW    = $clog2(MAX_POINTS);
  localparam int unsigned PCW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned SUM_W = kmmc_pkg::COORD_BITS + PCW;
  localparam int unsigned LAT   = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ASSIGN,
    ST_UPD_SEL,
    ST_UPD_WAIT,
    ST_ROUND
  } state_e;

  state_e              state_q;
  logic [12:0]         cfg_np_q;
  logic [4:0]          cfg_k_q;
  logic [7:0]          cfg_lim_q;
  logic                m_valid_q;
  kmmc_pkg::result_t   m_data_q;
  logic [PCW-1:0]      np_q;
  logic [CW:0]         k_q;
  logic [7:0]          lim_q;
  logic [PCW-1:0]      issue_q;
  logic [PCW-1:0]      retire_q;
  logic [PCW-1:0]      clear_from_q;
  logic                first_q;
  logic                changed_q;
  logic [7:0]          rounds_q;
  logic [CW:0]         upd_n_q;
  logic [kmmc_pkg::DIM_IW-1:0] upd_d_q;
  logic [kmmc_pkg::IDX_W-1:0]  rd_idx_q;
  logic                rd_ok_q;
  logic                rd_vld_q;
  logic [PW-1:0]       rd_addr_q;

  kmmc_pkg::point_t    point_mem [MAX_POINTS];
  logic [CW-1:0]       asgn_mem  [MAX_POINTS];
  kmmc_pkg::point_t    pt_rd_q;
  logic [CW-1:0]       as_rd_q;
  kmmc_pkg::point_t    cent_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]    sum_q  [MAX_CLUSTERS][kmmc_pkg::DIMS];
  logic [PCW-1:0]      cnt_q  [MAX_CLUSTERS];

  logic                dl_vld_q  [LAT];
  kmmc_pkg::point_t    dl_pt_q   [LAT];
  logic [CW-1:0]       dl_old_q  [LAT];
  logic [PW-1:0]       dl_addr_q [LAT];

  kmmc_pkg::item_t     item;
  kmmc_pkg::func_e     func;
  kmmc_pkg::point_t    pt_w;
  logic                in_acc;
  logic                issuing;
  logic [PW-1:0]       rd_addr;
  logic                ret_vld;
  logic [CW-1:0]       new_c;
  logic [CW-1:0]       old_c;
  logic [CW-1:0]       rd_c;
  logic [7:0]          rounds_inc;
  logic                round_end;
  logic                sum_clr;
  logic                div_start;
  logic                div_done;
  kmmc_pkg::coord_t    div_quot;
  logic [CW-1:0]       upd_n;
  logic [CW:0]         k_d;
  logic [PCW-1:0]      np_d;
  logic [kmmc_pkg::DIST_W:0] lane_dist [MAX_CLUSTERS];
  kmmc_pkg::result_t   rd_res;

  assign item    = kmmc_pkg::item_t'(s_axis_tdata);
  assign func    = kmmc_pkg::func_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign pt_w[0] = item.coord_a;
  assign pt_w[1] = item.coord_b;
  assign pt_w[2] = item.coord_c;

  assign issuing  = (state_q == ST_ASSIGN) && (issue_q < np_q);
  assign rd_addr  = (state_q == ST_IDLE) ? PW'(item.index) : issue_q[PW-1:0];
  assign ret_vld  = dl_vld_q[LAT-1];
  assign old_c    = first_q ? '0 : dl_old_q[LAT-1];
  assign rounds_inc = rounds_q + 8'd1;
  assign round_end  = rounds_inc >= lim_q;
  assign upd_n      = upd_n_q[CW-1:0];
  assign div_start  = (state_q == ST_UPD_SEL) && (upd_n_q != k_q) && (cnt_q[upd_n] != '0);
  assign sum_clr    = (state_q == ST_IDLE && in_acc && func == kmmc_pkg::FUNC_RUN) ||
                      (state_q == ST_ROUND && !round_end);

  always_comb begin
    if (cfg_k_q == 5'd0) begin
      k_d = (CW+1)'(1);
    end else if (32'(cfg_k_q) > 32'(MAX_CLUSTERS)) begin
      k_d = (CW+1)'(MAX_CLUSTERS);
    end else begin
      k_d = (CW+1)'(cfg_k_q);
    end
    np_d = (32'(cfg_np_q) > 32'(MAX_POINTS)) ? PCW'(MAX_POINTS) : PCW'(cfg_np_q);
  end

  always_comb begin
    rd_c   = (32'(rd_idx_q) < 32'(clear_from_q)) ? as_rd_q : '0;
    rd_res = '0;
    if (rd_ok_q) begin
      rd_res.cluster = 4'(rd_c);
      rd_res.mean_a  = cent_q[rd_c][0];
      rd_res.mean_b  = cent_q[rd_c][1];
      rd_res.mean_c  = cent_q[rd_c][2];
    end
  end

  for (genvar n = 0; n < MAX_CLUSTERS; n++) begin : g_lane
    kmmc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (32'(n) < 32'(k_q)),
      .point_i (pt_rd_q),
      .cent_i  (cent_q[n]),
      .dist_o  (lane_dist[n])
    );
  end

  kmmc_merge #(
    .NUM (MAX_CLUSTERS)
  ) u_merge (
    .clk_i  (clk_i),
    .dist_i (lane_dist),
    .idx_o  (new_c)
  );

  kmmc_div #(
    .CNT_W (PCW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[upd_n][upd_d_q]),
    .divisor_i  (cnt_q[upd_n]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && func == kmmc_pkg::FUNC_LOAD_POINT &&
        32'(item.index) < 32'(MAX_POINTS)) begin
      point_mem[PW'(item.index)] <= pt_w;
    end
    if (ret_vld) begin
      asgn_mem[dl_addr_q[LAT-1]] <= new_c;
    end
    pt_rd_q <= point_mem[rd_addr];
    as_rd_q <= asgn_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && func == kmmc_pkg::FUNC_LOAD_SEED &&
        32'(item.index) < 32'(MAX_CLUSTERS)) begin
      cent_q[CW'(item.index)] <= pt_w;
    end
    if (div_done) begin
      cent_q[upd_n][upd_d_q] <= div_quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_clr) begin
      for (int n = 0; n < int'(MAX_CLUSTERS); n++) begin
        cnt_q[n] <= '0;
        for (int d = 0; d < int'(kmmc_pkg::DIMS); d++) begin
          sum_q[n][d] <= '0;
        end
      end
    end else if (ret_vld) begin
      cnt_q[new_c] <= cnt_q[new_c] + 1'b1;
      for (int d = 0; d < int'(kmmc_pkg::DIMS); d++) begin
        sum_q[new_c][d] <= sum_q[new_c][d] + SUM_W'(dl_pt_q[LAT-1][d]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_pt_q[0]   <= pt_rd_q;
    dl_old_q[0]  <= as_rd_q;
    dl_addr_q[0] <= rd_addr_q;
    for (int j = 1; j < int'(LAT); j++) begin
      dl_pt_q[j]   <= dl_pt_q[j-1];
      dl_old_q[j]  <= dl_old_q[j-1];
      dl_addr_q[j] <= dl_addr_q[j-1];
    end
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      for (int j = 0; j < int'(LAT); j++) begin
        dl_vld_q[j] <= 1'b0;
      end
    end else begin
      rd_vld_q    <= issuing;
      dl_vld_q[0] <= rd_vld_q;
      for (int j = 1; j < int'(LAT); j++) begin
        dl_vld_q[j] <= dl_vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_np_q     <= kmmc_pkg::NUM_POINTS_RST;
      cfg_k_q      <= kmmc_pkg::NUM_CLUSTERS_RST;
      cfg_lim_q    <= kmmc_pkg::MAX_ITERATIONS_RST;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      np_q         <= '0;
      k_q          <= '0;
      lim_q        <= '0;
      issue_q      <= '0;
      retire_q     <= '0;
      clear_from_q <= '0;
      first_q      <= 1'b0;
      changed_q    <= 1'b0;
      rounds_q     <= '0;
      upd_n_q      <= '0;
      upd_d_q      <= '0;
      rd_idx_q     <= '0;
      rd_ok_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (kmmc_pkg::cfg_idx_e'(cfg_idx_i))
          kmmc_pkg::CFG_NUM_POINTS:     cfg_np_q  <= cfg_data_i;
          kmmc_pkg::CFG_NUM_CLUSTERS:   cfg_k_q   <= cfg_data_i[4:0];
          kmmc_pkg::CFG_MAX_ITERATIONS: cfg_lim_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && !in_acc) begin
        m_valid_q <= 1'b0;
      end
      if (issuing) begin
        issue_q <= issue_q + 1'b1;
      end
      if (ret_vld) begin
        retire_q <= retire_q + 1'b1;
        if (new_c != old_c) begin
          changed_q <= 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (func)
              kmmc_pkg::FUNC_RUN: begin
                m_valid_q    <= 1'b0;
                np_q         <= np_d;
                k_q          <= k_d;
                lim_q        <= (cfg_lim_q == 8'd0) ? 8'd1 : cfg_lim_q;
                clear_from_q <= np_d;
                issue_q      <= '0;
                retire_q     <= '0;
                first_q      <= 1'b1;
                changed_q    <= 1'b0;
                rounds_q     <= '0;
                upd_n_q      <= '0;
                upd_d_q      <= '0;
                state_q      <= ST_ASSIGN;
              end
              kmmc_pkg::FUNC_READ: begin
                m_valid_q <= 1'b0;
                rd_idx_q  <= item.index;
                rd_ok_q   <= 32'(item.index) < 32'(MAX_POINTS);
                state_q   <= ST_READ;
              end
              default: begin
                m_valid_q <= 1'b1;
                m_data_q  <= '0;
              end
            endcase
          end
        end
        ST_READ: begin
          m_valid_q <= 1'b1;
          m_data_q  <= rd_res;
          state_q   <= ST_IDLE;
        end
        ST_ASSIGN: begin
          if (retire_q == np_q) begin
            if (!changed_q) begin
              m_valid_q <= 1'b1;
              m_data_q  <= '{pad: '0, converged: 1'b1, rounds: rounds_q,
                             mean_c: '0, mean_b: '0, mean_a: '0, cluster: '0};
              state_q   <= ST_IDLE;
            end else begin
              upd_n_q <= '0;
              upd_d_q <= '0;
              state_q <= ST_UPD_SEL;
            end
          end
        end
        ST_UPD_SEL: begin
          if (upd_n_q == k_q) begin
            state_q <= ST_ROUND;
          end else if (cnt_q[upd_n] == '0) begin
            upd_n_q <= upd_n_q + 1'b1;
          end else begin
            state_q <= ST_UPD_WAIT;
          end
        end
        ST_UPD_WAIT: begin
          if (div_done) begin
            if (upd_d_q == kmmc_pkg::DIM_IW'(kmmc_pkg::DIMS - 1)) begin
              upd_d_q <= '0;
              upd_n_q <= upd_n_q + 1'b1;
            end else begin
              upd_d_q <= upd_d_q + 1'b1;
            end
            state_q <= ST_UPD_SEL;
          end
        end
        ST_ROUND: begin
          rounds_q <= rounds_inc;
          if (round_end) begin
            m_valid_q <= 1'b1;
            m_data_q  <= '{pad: '0, converged: 1'b0, rounds: rounds_inc,
                           mean_c: '0, mean_b: '0, mean_a: '0, cluster: '0};
            state_q   <= ST_IDLE;
          end else begin
            issue_q   <= '0;
            retire_q  <= '0;
            changed_q <= 1'b0;
            first_q   <= 1'b0;
            state_q   <= ST_ASSIGN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE))
    else $error("input taken while a transaction is still in progress");

  a_retire_le_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ASSIGN) |-> (retire_q <= issue_q))
    else $error("more points retired than issued");

  a_retire_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_vld |-> (state_q == ST_ASSIGN))
    else $error("assignment retired outside an assignment pass");

  a_div_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_UPD_WAIT))
    else $error("divider finished outside the update step");

endmodule

/* tb/kmmc_checker.sv */
// Checker for the k-means clustering block: watches the input, output and register
// channels, predicts each result and compares it field by field. Depends on kmmc_pkg.
module kmmc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output int          fails_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = 4096;
  localparam int unsigned NCL  = 16;

  kmmc_pkg::coord_t  pts [NPTS][kmmc_pkg::DIMS];
  logic [3:0]        asg [NPTS];
  kmmc_pkg::coord_t  cent [NCL][kmmc_pkg::DIMS];
  int unsigned       np_reg, k_reg, iter_reg;
  kmmc_pkg::result_t due_q[$];

  initial fails_o = 0;

  function automatic int unsigned l1_dist(int unsigned p, int unsigned c);
    int unsigned acc;
    acc = 0;
    for (int d = 0; d < kmmc_pkg::DIMS; d++) begin
      acc += (pts[p][d] >= cent[c][d]) ? pts[p][d] - cent[c][d] : cent[c][d] - pts[p][d];
    end
    return acc;
  endfunction

  task automatic cluster_run(output logic [7:0] rounds, output logic conv);
    int unsigned np, k, lim, best, bestd, dd, r;
    int unsigned cnt [NCL];
    longint unsigned sum [NCL][kmmc_pkg::DIMS];
    bit chg;
    np = (np_reg > NPTS) ? NPTS : np_reg;
    k = (k_reg < 1) ? 1 : ((k_reg > NCL) ? NCL : k_reg);
    lim = (iter_reg == 0) ? 1 : iter_reg;
    for (int i = 0; i < NPTS; i++) asg[i] = '0;
    r = 0;
    conv = 1'b0;
    forever begin
      chg = 1'b0;
      for (int i = 0; i < np; i++) begin
        best = 0;
        bestd = l1_dist(i, 0);
        for (int n = 1; n < k; n++) begin
          dd = l1_dist(i, n);
          if (dd < bestd) begin
            bestd = dd;
            best = n;
          end
        end
        if (best != asg[i]) chg = 1'b1;
        asg[i] = best[3:0];
      end
      if (!chg) begin
        conv = 1'b1;
        break;
      end
      for (int n = 0; n < NCL; n++) begin
        cnt[n] = 0;
        for (int d = 0; d < kmmc_pkg::DIMS; d++) sum[n][d] = 0;
      end
      for (int i = 0; i < np; i++) begin
        cnt[asg[i]]++;
        for (int d = 0; d < kmmc_pkg::DIMS; d++) sum[asg[i]][d] += pts[i][d];
      end
      for (int n = 0; n < k; n++) begin
        if (cnt[n] != 0) begin
          for (int d = 0; d < kmmc_pkg::DIMS; d++) begin
            cent[n][d] = kmmc_pkg::coord_t'(sum[n][d] / cnt[n]);
          end
        end
      end
      r++;
      if (r >= lim) break;
    end
    rounds = r[7:0];
  endtask

  task automatic predict_item(input kmmc_pkg::func_e fn, input kmmc_pkg::item_t it);
    kmmc_pkg::result_t res;
    logic [7:0] rnd;
    logic cv;
    res = '0;
    case (fn)
      kmmc_pkg::FUNC_LOAD_POINT: begin
        pts[it.index][0] = it.coord_a;
        pts[it.index][1] = it.coord_b;
        pts[it.index][2] = it.coord_c;
      end
      kmmc_pkg::FUNC_LOAD_SEED: begin
        if (it.index < NCL) begin
          cent[it.index][0] = it.coord_a;
          cent[it.index][1] = it.coord_b;
          cent[it.index][2] = it.coord_c;
        end
      end
      kmmc_pkg::FUNC_RUN: begin
        cluster_run(rnd, cv);
        res.rounds = rnd;
        res.converged = cv;
      end
      default: begin
        res.cluster = asg[it.index];
        res.mean_a = cent[res.cluster][0];
        res.mean_b = cent[res.cluster][1];
        res.mean_c = cent[res.cluster][2];
      end
    endcase
    due_q.push_back(res);
  endtask

  task automatic check_result(input kmmc_pkg::result_t got);
    kmmc_pkg::result_t exp_r;
    if (due_q.size() == 0) begin
      $error("result transaction with no expectation waiting: %h", got);
      fails_o++;
      return;
    end
    exp_r = due_q.pop_front();
    if (got.cluster !== exp_r.cluster) begin
      $error("cluster: expected %0d, actual %0d", exp_r.cluster, got.cluster);
      fails_o++;
    end
    if (got.mean_a !== exp_r.mean_a) begin
      $error("mean_a: expected %0d, actual %0d", exp_r.mean_a, got.mean_a);
      fails_o++;
    end
    if (got.mean_b !== exp_r.mean_b) begin
      $error("mean_b: expected %0d, actual %0d", exp_r.mean_b, got.mean_b);
      fails_o++;
    end
    if (got.mean_c !== exp_r.mean_c) begin
      $error("mean_c: expected %0d, actual %0d", exp_r.mean_c, got.mean_c);
      fails_o++;
    end
    if (got.rounds !== exp_r.rounds) begin
      $error("rounds: expected %0d, actual %0d", exp_r.rounds, got.rounds);
      fails_o++;
    end
    if (got.converged !== exp_r.converged) begin
      $error("converged: expected %0d, actual %0d", exp_r.converged, got.converged);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_reg = kmmc_pkg::NUM_POINTS_RST;
      k_reg = kmmc_pkg::NUM_CLUSTERS_RST;
      iter_reg = kmmc_pkg::MAX_ITERATIONS_RST;
      for (int i = 0; i < NPTS; i++) asg[i] = '0;
      due_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (kmmc_pkg::cfg_idx_e'(cfg_idx_i))
          kmmc_pkg::CFG_NUM_POINTS:     np_reg = cfg_data_i;
          kmmc_pkg::CFG_NUM_CLUSTERS:   k_reg = cfg_data_i[4:0];
          kmmc_pkg::CFG_MAX_ITERATIONS: iter_reg = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(kmmc_pkg::result_t'(m_axis_tdata));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(kmmc_pkg::func_e'(s_axis_tuser), kmmc_pkg::item_t'(s_axis_tdata));
      end
      pending_o = due_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the k-means clustering testbench: clock, reset, register writes, stimulus
// and flow control. Depends on kmmc_pkg, kmmc_checker and kmeans_manhattan_clustering.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT = 8000000;
  localparam int unsigned LOADED = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;
  int          fails;
  int          pending;
  bit          quiet;
  bit          hold_req;
  int unsigned stall_left;
  int unsigned cycles;

  kmeans_manhattan_clustering DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  kmmc_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fails_o(fails), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side flow control, including the long hold-off used to back up the block.
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(5) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic kmmc_pkg::coord_t rnd_c();
    return kmmc_pkg::coord_t'($urandom_range(255));
  endfunction

  task automatic write_reg(input kmmc_pkg::cfg_idx_e idx, input logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send(input kmmc_pkg::func_e fn, input logic [11:0] idx,
                      input kmmc_pkg::coord_t a, input kmmc_pkg::coord_t b,
                      input kmmc_pkg::coord_t c);
    kmmc_pkg::item_t it;
    it = '0;
    it.index = idx;
    it.coord_a = a;
    it.coord_b = b;
    it.coord_c = c;
    @(negedge clk_i);
    if (!quiet && $urandom_range(7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = fn;
    s_axis_tdata = it;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [11:0] pick_index();
    return ($urandom_range(4) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(LOADED - 1));
  endfunction

  task automatic configure(input int unsigned np, input int unsigned k, input int unsigned it);
    write_reg(kmmc_pkg::CFG_NUM_POINTS, 13'(np));
    write_reg(kmmc_pkg::CFG_NUM_CLUSTERS, 13'(k));
    write_reg(kmmc_pkg::CFG_MAX_ITERATIONS, 13'(it));
  endtask

  initial begin
    int unsigned np, k, it, sel;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = kmmc_pkg::FUNC_LOAD_POINT;
    cfg_we_i = 1'b0;
    cfg_idx_i = kmmc_pkg::CFG_NUM_POINTS;
    cfg_data_i = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    configure(LOADED, 16, 255);
    for (int n = 0; n < 16; n++) begin
      send(kmmc_pkg::FUNC_LOAD_SEED, 12'(n), rnd_c(), rnd_c(), rnd_c());
    end
    for (int i = 0; i < LOADED; i++) begin
      if (i == 0) send(kmmc_pkg::FUNC_LOAD_POINT, 12'(i), 8'd0, 8'd0, 8'd0);
      else if (i == 1) send(kmmc_pkg::FUNC_LOAD_POINT, 12'(i), 8'd255, 8'd255, 8'd255);
      else send(kmmc_pkg::FUNC_LOAD_POINT, 12'(i), rnd_c(), rnd_c(), rnd_c());
    end

    send(kmmc_pkg::FUNC_LOAD_SEED, 12'd16, 8'd255, 8'd255, 8'd255);
    send(kmmc_pkg::FUNC_LOAD_SEED, 12'd4095, 8'd1, 8'd2, 8'd3);
    send(kmmc_pkg::FUNC_LOAD_POINT, 12'd4095, 8'd255, 8'd0, 8'd255);
    send(kmmc_pkg::FUNC_READ, 12'd4095, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd0, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd1, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'(LOADED - 1), 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd3000, 8'd0, 8'd0, 8'd0);
    drain();

    configure(0, 0, 0);
    send(kmmc_pkg::FUNC_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd5, 8'd0, 8'd0, 8'd0);
    drain();
    configure(1, 31, 1);
    send(kmmc_pkg::FUNC_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd0, 8'd0, 8'd0, 8'd0);
    drain();
    configure(LOADED, 1, 1);
    send(kmmc_pkg::FUNC_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
    send(kmmc_pkg::FUNC_READ, 12'd7, 8'd0, 8'd0, 8'd0);
    drain();

    for (int p = 0; p < 25; p++) begin
      quiet = (p >= 20);
      np = ($urandom_range(9) == 0) ? LOADED : $urandom_range(1, 64);
      sel = $urandom_range(15);
      k = (sel == 0) ? 0 : ((sel == 1) ? 31 : $urandom_range(1, 16));
      sel = $urandom_range(15);
      it = (sel == 0) ? 0 : ((sel == 1) ? 255 : $urandom_range(1, 20));
      configure(np, k, it);
      if (p == 5) hold_req = 1'b1;
      for (int j = 0; j < 50; j++) begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          send(kmmc_pkg::FUNC_LOAD_POINT, pick_index(), rnd_c(), rnd_c(), rnd_c());
        end else if (sel < 45) begin
          send(kmmc_pkg::FUNC_LOAD_SEED, 12'($urandom_range(31)), rnd_c(), rnd_c(),
               rnd_c());
        end else if (sel < 95) begin
          send(kmmc_pkg::FUNC_READ, pick_index(), rnd_c(), rnd_c(), rnd_c());
        end else begin
          send(kmmc_pkg::FUNC_RUN, pick_index(), rnd_c(), rnd_c(), rnd_c());
        end
      end
      send(kmmc_pkg::FUNC_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
      for (int j = 0; j < 5; j++) send(kmmc_pkg::FUNC_READ, pick_index(), 8'd0, 8'd0, 8'd0);
      drain();
    end

    repeat (100) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/kmmc_pkg.sv
hdl/kmmc_lane.sv
hdl/kmmc_merge.sv
hdl/kmmc_div.sv
hdl/kmeans_manhattan_clustering.sv
tb/kmmc_checker.sv
tb/testbench.sv
